// ===== rtl/utp_pkg.sv =====
package utp_pkg;

	localparam int unsigned IdWidth    = 128;
	localparam int unsigned HalfWidth  = 64;
	localparam int unsigned CountWidth = 6;

	localparam logic [CountWidth-1:0] DigitsTotal = 6'd32;
	localparam logic [CountWidth-1:0] DashAt0     = 6'd8;
	localparam logic [CountWidth-1:0] DashAt1     = 6'd12;
	localparam logic [CountWidth-1:0] DashAt2     = 6'd16;
	localparam logic [CountWidth-1:0] DashAt3     = 6'd20;

	localparam logic [7:0] CharDash  = 8'h2D;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharCr    = 8'h0D;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharUpA   = 8'h41;
	localparam logic [7:0] CharUpF   = 8'h46;
	localparam logic [7:0] CharLowA  = 8'h61;
	localparam logic [7:0] CharLowF  = 8'h66;

	typedef enum logic [2:0] {
		PHASE_LEAD = 3'b001,
		PHASE_BODY = 3'b010,
		PHASE_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic       lead_space;
		logic       space;
		logic       dash;
		logic       hex;
		logic [3:0] nibble;
	} char_class_t;

	typedef struct packed {
		logic                 push;
		logic                 ok;
		logic [IdWidth-1:0]   id;
	} result_t;

endpackage

// ===== rtl/utp_char_if.sv =====
interface utp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       start_req;
	logic       end_of_text;

	modport source (output valid, output character, output start_req, output end_of_text,
		input ready);
	modport sink (input valid, input character, input start_req, input end_of_text,
		output ready);
endinterface

// ===== rtl/utp_id_if.sv =====
interface utp_id_if;
	logic        valid;
	logic        ready;
	logic [63:0] id_high;
	logic [63:0] id_low;
	logic        ok;

	modport source (output valid, output id_high, output id_low, output ok, input ready);
	modport sink (input valid, input id_high, input id_low, input ok, output ready);
endinterface

// ===== rtl/utp_char_class.sv =====
module utp_char_class import utp_pkg::*; (
	input  logic [7:0]  character,
	output char_class_t cls
);

	logic is_num;
	logic is_up;
	logic is_low;

	always_comb begin
		is_num = (character >= CharZero) && (character <= CharNine);
		is_up  = (character >= CharUpA) && (character <= CharUpF);
		is_low = (character >= CharLowA) && (character <= CharLowF);

		cls.space      = (character == CharSpace);
		cls.lead_space = cls.space || ((character >= CharTab) && (character <= CharCr));
		cls.dash       = (character == CharDash);
		cls.hex        = is_num || is_up || is_low;

		if (is_num) begin
			cls.nibble = character[3:0];
		end else begin
			// Letters a-f and A-F share the low three bits; value is 9 plus those bits.
			cls.nibble = 4'd9 + {1'b0, character[2:0]};
		end
	end

endmodule

// ===== rtl/utp_out_reg.sv =====
module utp_out_reg import utp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  result_t res,
	output logic    can_take,
	utp_id_if.source rsp
);

	logic               valid_q;
	logic               ok_q;
	logic [IdWidth-1:0] id_q;

	assign can_take = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= res.push;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && res.push) begin
			ok_q <= res.ok;
			id_q <= res.id;
		end
	end

	assign rsp.valid   = valid_q;
	assign rsp.ok      = ok_q;
	assign rsp.id_high = id_q[IdWidth-1:HalfWidth];
	assign rsp.id_low  = id_q[HalfWidth-1:0];

endmodule

// ===== rtl/uuid_text_parser.sv =====
// Output: a result is registered and appears in the cycle after the beat that completes it.
// Throughput: one character beat per cycle; input stalls only while a result
// waits on the output and the output is not ready.
// Reset: asynchronous, active low; the parser returns to skipping leading
// white space and holds no pending result.
module uuid_text_parser import utp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	utp_char_if.sink  req,
	utp_id_if.source  rsp
);

	phase_t                phase_q;
	logic [CountWidth-1:0] count_q;
	logic [IdWidth-1:0]    acc_q;

	phase_t                phase_cur;
	logic [CountWidth-1:0] count_cur;
	logic [IdWidth-1:0]    acc_cur;

	phase_t                phase_nxt;
	logic [CountWidth-1:0] count_nxt;
	logic [IdWidth-1:0]    acc_nxt;
	logic [CountWidth-1:0] count_inc;
	logic [IdWidth-1:0]    acc_shift;
	logic                  dash_ok;

	char_class_t cls;
	result_t     res;
	logic        can_take;
	logic        accept;

	utp_char_class u_class (
		.character(req.character),
		.cls      (cls)
	);

	utp_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.res     (res),
		.can_take(can_take),
		.rsp     (rsp)
	);

	assign req.ready = can_take;
	assign accept    = req.valid && can_take;

	always_comb begin
		phase_cur = req.start_req ? PHASE_LEAD : phase_q;
		count_cur = req.start_req ? '0 : count_q;
		acc_cur   = req.start_req ? '0 : acc_q;

		count_inc = count_cur + 1'b1;
		acc_shift = {acc_cur[IdWidth-5:0], cls.nibble};
		dash_ok   = (count_cur == DashAt0) || (count_cur == DashAt1) ||
			(count_cur == DashAt2) || (count_cur == DashAt3);

		phase_nxt = phase_cur;
		count_nxt = count_cur;
		acc_nxt   = acc_cur;
		res.push  = 1'b0;
		res.ok    = 1'b0;
		res.id    = '0;

		if (req.valid && ((phase_cur == PHASE_LEAD) || (phase_cur == PHASE_BODY))) begin
			if (req.end_of_text) begin
				res.push  = 1'b1;
				phase_nxt = PHASE_DONE;
				acc_nxt   = '0;
			end else if ((phase_cur == PHASE_LEAD) && cls.lead_space) begin
				phase_nxt = PHASE_LEAD;
			end else if (cls.hex) begin
				acc_nxt   = acc_shift;
				count_nxt = count_inc;
				if (count_inc >= DigitsTotal) begin
					res.push  = 1'b1;
					res.ok    = 1'b1;
					res.id    = acc_shift;
					phase_nxt = PHASE_DONE;
				end else begin
					phase_nxt = PHASE_BODY;
				end
			end else if ((cls.dash && dash_ok) || cls.space) begin
				phase_nxt = PHASE_BODY;
			end else begin
				res.push  = 1'b1;
				phase_nxt = PHASE_DONE;
				acc_nxt   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_LEAD;
			count_q <= '0;
			acc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
			acc_q   <= acc_nxt;
		end
	end

endmodule

// ===== bench/tb.sv =====
module tb;
	import utp_pkg::*;

	typedef enum {CHK_MODEL, CHK_OK, CHK_FAIL} row_check_t;

	typedef struct {
		bit                 start;
		int                 lead;
		string              text;
		bit                 eot;
		row_check_t         chk;
		logic [IdWidth-1:0] id;
	} text_row_t;

	typedef struct packed {
		logic [HalfWidth-1:0] id_high;
		logic [HalfWidth-1:0] id_low;
		logic                 ok;
	} id_beat_t;

	typedef struct packed {
		logic [7:0] character;
		logic       start_req;
		logic       end_of_text;
	} char_beat_t;

	localparam int RandomItems = 1600;
	localparam int QuietLimit  = 1000;
	localparam int DirRows     = 17;

	logic clk = 1'b0;
	logic arst_n;

	utp_char_if req();
	utp_id_if   rsp();

	uuid_text_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	phase_t                scan_phase;
	logic [CountWidth-1:0] scan_count;
	logic [IdWidth-1:0]    scan_acc;

	id_beat_t   expected_ids[$];
	char_beat_t text_beats[$];

	int errors       = 0;
	int live_items   = 0;
	int ok_count     = 0;
	int fail_count   = 0;
	int quiet_cycles = 0;
	int gap_pct      = 0;
	int stall_pct    = 0;

	int gap_table[4]   = '{0, 52, 0, 14};
	int stall_table[4] = '{0, 0, 52, 14};

	text_row_t dir_rows[DirRows] = '{
		'{1'b0, -1, "00000000-0000-0000-0000-000000000000", 1'b0, CHK_OK, '0},
		'{1'b1, -1, "FFFFFFFF-FFFF-FFFF-FFFF-FFFFFFFFFFFF", 1'b0, CHK_OK, '1},
		'{1'b1, -1, " \t\n\013\014\0150123456789abcdefABCDEF0123456789", 1'b0, CHK_MODEL, '0},
		'{1'b1, -1, "", 1'b1, CHK_FAIL, '0},
		'{1'b1, -1, "1234-", 1'b0, CHK_FAIL, '0},
		'{1'b0, -1, "abc", 1'b1, CHK_MODEL, '0},
		'{1'b1, -1, "12345678--9abc - def0-1234-56789ABCDEF0", 1'b0, CHK_MODEL, '0},
		'{1'b1, -1, "0123456", 1'b1, CHK_FAIL, '0},
		'{1'b1, 8'h00, "", 1'b0, CHK_FAIL, '0},
		'{1'b1, 8'hFF, "", 1'b0, CHK_FAIL, '0},
		'{1'b1, -1, " \t1\t", 1'b0, CHK_FAIL, '0},
		'{1'b1, -1, "-", 1'b0, CHK_FAIL, '0},
		'{1'b1, -1, "g", 1'b0, CHK_FAIL, '0},
		'{1'b1, -1, "  ", 1'b1, CHK_FAIL, '0},
		'{1'b1, -1, "0123456789abcdef0123456789ABCDEF-zz", 1'b0, CHK_MODEL, '0},
		'{1'b1, -1, "abcd", 1'b0, CHK_MODEL, '0},
		'{1'b1, -1, "fedcba98-7654-3210-0123-456789abcdef", 1'b0, CHK_MODEL, '0}
	};

	function automatic bit dash_point(input logic [CountWidth-1:0] n);
		return n == DashAt0 || n == DashAt1 || n == DashAt2 || n == DashAt3;
	endfunction

	function automatic void scan_char(input logic [7:0] c, input bit s, input bit e,
		output bit used, output bit produced, output id_beat_t res);
		logic [4:0] nib;
		used = 1'b0;
		produced = 1'b0;
		res = '0;
		if (s) begin
			scan_phase = PHASE_LEAD;
			scan_count = '0;
			scan_acc = '0;
		end
		if (scan_phase != PHASE_LEAD && scan_phase != PHASE_BODY)
			return;
		used = 1'b1;
		if (e) begin
			produced = 1'b1;
			scan_phase = PHASE_DONE;
			scan_acc = '0;
			return;
		end
		if (scan_phase == PHASE_LEAD) begin
			if (c == CharSpace || (c >= CharTab && c <= CharCr))
				return;
			scan_phase = PHASE_BODY;
		end
		nib = 5'd16;
		if (c >= CharZero && c <= CharNine)
			nib = {1'b0, 4'(c - CharZero)};
		else if (c >= CharUpA && c <= CharUpF)
			nib = {1'b0, 4'(c - CharUpA + 8'd10)};
		else if (c >= CharLowA && c <= CharLowF)
			nib = {1'b0, 4'(c - CharLowA + 8'd10)};
		if (!nib[4]) begin
			scan_acc = {scan_acc[IdWidth-5:0], nib[3:0]};
			scan_count = scan_count + 1'b1;
			if (scan_count >= DigitsTotal) begin
				produced = 1'b1;
				res = {scan_acc, 1'b1};
				scan_phase = PHASE_DONE;
			end
			return;
		end
		if ((c == CharDash && dash_point(scan_count)) || c == CharSpace)
			return;
		produced = 1'b1;
		scan_phase = PHASE_DONE;
		scan_acc = '0;
	endfunction

	task automatic send_beat(input char_beat_t b);
		while ($urandom_range(99) < gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.character <= b.character;
		req.start_req <= b.start_req;
		req.end_of_text <= b.end_of_text;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic apply_item(input char_beat_t b, input row_check_t chk,
		input logic [IdWidth-1:0] want, output bit produced);
		bit used;
		id_beat_t res;
		send_beat(b);
		scan_char(b.character, b.start_req, b.end_of_text, used, produced, res);
		if (used)
			live_items++;
		if (produced) begin
			if (chk == CHK_OK)
				res = {want, 1'b1};
			else if (chk == CHK_FAIL)
				res = '0;
			expected_ids.push_back(res);
		end
	endtask

	task automatic run_row(input text_row_t r);
		char_beat_t b;
		bit first;
		bit produced;
		bit got;
		int i;
		first = 1'b1;
		got = 1'b0;
		if (r.lead >= 0) begin
			b.character = 8'(r.lead);
			b.start_req = r.start;
			b.end_of_text = 1'b0;
			apply_item(b, r.chk, r.id, produced);
			got |= produced;
			first = 1'b0;
		end
		for (i = 0; i < r.text.len(); i++) begin
			b.character = r.text[i];
			b.start_req = r.start && first;
			b.end_of_text = 1'b0;
			apply_item(b, r.chk, r.id, produced);
			got |= produced;
			first = 1'b0;
		end
		if (r.eot) begin
			b.character = 8'($urandom_range(255));
			b.start_req = r.start && first;
			b.end_of_text = 1'b1;
			apply_item(b, r.chk, r.id, produced);
			got |= produced;
		end
		if (r.chk != CHK_MODEL && !got) begin
			$display("%0t: text \"%s\" gave no result, one expected", $time, r.text);
			errors++;
		end
	endtask

	function automatic void push_char(input logic [7:0] c, input bit e);
		char_beat_t b;
		b.character = c;
		b.start_req = 1'b0;
		b.end_of_text = e;
		text_beats.push_back(b);
	endfunction

	function automatic logic [7:0] hex_char();
		logic [7:0] v;
		v = 8'($urandom_range(15));
		if (v < 8'd10)
			return CharZero + v;
		return ($urandom_range(1) ? CharUpA : CharLowA) + v - 8'd10;
	endfunction

	function automatic logic [7:0] lead_space_char();
		int r;
		r = $urandom_range(5);
		return (r == 5) ? CharSpace : CharTab + 8'(r);
	endfunction

	function automatic void push_digits(input int n);
		int i;
		for (i = 0; i < n; i++) begin
			if (dash_point(CountWidth'(i)) && $urandom_range(3) != 0) begin
				push_char(CharDash, 1'b0);
				if ($urandom_range(7) == 0)
					push_char(CharDash, 1'b0);
			end
			if (i > 0 && $urandom_range(19) == 0)
				push_char(CharSpace, 1'b0);
			push_char(hex_char(), 1'b0);
		end
	endfunction

	task automatic random_text();
		char_beat_t b;
		int kind;
		bit produced;
		text_beats.delete();
		kind = $urandom_range(99);
		if (kind < 90)
			repeat ($urandom_range(3))
				push_char(lead_space_char(), 1'b0);
		if (kind < 70) begin
			push_digits(32);
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 4))
					push_char(8'($urandom_range(255)), 1'b0);
			if ($urandom_range(4) == 0)
				push_char(8'($urandom_range(255)), 1'b1);
		end else if (kind < 90) begin
			push_digits($urandom_range(31));
			case ($urandom_range(2))
				0: push_char(8'($urandom_range(255)), 1'b1);
				1: push_char(CharDash, 1'b0);
				default: push_char(8'($urandom_range(255)), 1'b0);
			endcase
			if ($urandom_range(1))
				push_char(8'($urandom_range(255)), 1'b1);
		end else begin
			repeat ($urandom_range(1, 8)) begin
				b.character = 8'($urandom_range(255));
				b.start_req = ($urandom_range(7) == 0);
				b.end_of_text = ($urandom_range(7) == 0);
				text_beats.push_back(b);
			end
		end
		if (kind < 90 && text_beats.size() > 0)
			text_beats[0].start_req = ($urandom_range(11) != 0);
		foreach (text_beats[i])
			apply_item(text_beats[i], CHK_MODEL, '0, produced);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_ids.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		id_beat_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_ids.size() == 0) begin
				$display("%0t: unexpected result beat, id %h_%h ok %b", $time,
					rsp.id_high, rsp.id_low, rsp.ok);
				errors++;
			end else begin
				want = expected_ids.pop_front();
				if (rsp.id_high !== want.id_high) begin
					$display("%0t: id_high expected %h, got %h", $time, want.id_high,
						rsp.id_high);
					errors++;
				end
				if (rsp.id_low !== want.id_low) begin
					$display("%0t: id_low expected %h, got %h", $time, want.id_low,
						rsp.id_low);
					errors++;
				end
				if (rsp.ok !== want.ok) begin
					$display("%0t: ok expected %b, got %b", $time, want.ok, rsp.ok);
					errors++;
				end
				if (want.ok)
					ok_count++;
				else
					fail_count++;
			end
		end
	end

	initial begin
		while (quiet_cycles < QuietLimit)
			@(posedge clk);
		$display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int base;
		int ph;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.character = '0;
		req.start_req = 1'b0;
		req.end_of_text = 1'b0;
		scan_phase = PHASE_LEAD;
		scan_count = '0;
		scan_acc = '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			run_row(dir_rows[i]);
		drain();
		base = live_items;
		for (ph = 0; ph < 4; ph++) begin
			gap_pct = gap_table[ph];
			stall_pct = stall_table[ph];
			while (live_items - base < RandomItems * (ph + 1) / 4) begin
				random_text();
				if ($urandom_range(39) == 0)
					drain();
			end
			drain();
		end
		repeat (10)
			@(posedge clk);
		$display("Ran %0d directed texts and %0d parsed characters under four handshake patterns.",
			DirRows, live_items);
		$display("Checked %0d identifiers read in full and %0d rejected texts.", ok_count,
			fail_count);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/utp_pkg.sv
rtl/utp_char_if.sv
rtl/utp_id_if.sv
rtl/utp_char_class.sv
rtl/utp_out_reg.sv
rtl/uuid_text_parser.sv
bench/tb.sv
